### sv/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Types and constants shared by the sample statistics engine modules.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned VALUE_BINS  = 101;

  localparam int unsigned VAL_W   = 7;   // sample value / bin index
  localparam int unsigned CNT_W   = 11;  // sample count, histogram entry
  localparam int unsigned POS_W   = 10;  // arrival position
  localparam int unsigned SUM_W   = 17;
  localparam int unsigned SQ_W    = 24;
  localparam int unsigned PROD_W  = 34;  // n*sumsq and sum^2
  localparam int unsigned N2_W    = 21;  // n^2

  localparam int unsigned DIV_NUM_W = PROD_W + 8;
  localparam int unsigned DIV_DEN_W = N2_W;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [VAL_W-1:0] BIN_LAST = VAL_W'(VALUE_BINS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SAMPLES);

  typedef struct packed {
    logic [6:0] sample;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [14:0] mean_q8;
    logic [19:0] variance_q8;
    logic [6:0]  largest;
    logic [6:0]  smallest;
    logic [6:0]  mode_value;
    logic [7:0]  median_x2;
    logic [10:0] set_size;
    logic        overflow;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // sample transfer this cycle
    logic clear_wr;    // post-reset histogram sweep
    logic scan_init;
    logic scan_issue;  // read bin k
    logic mult;
    logic div_start;
    logic div_var;     // divider operands: variance (else mean)
    logic mean_wait;
    logic var_wait;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic k_last;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

### sv/sse_div.sv
// ----------------------------------------------------------------------------
// sse_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sse_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sse_pkg::DIV_NUM_W-1:0]    num,
  input  logic [sse_pkg::DIV_DEN_W-1:0]    den,
  output logic                             done,
  output logic [sse_pkg::DIV_NUM_W-1:0]    quot
);

  logic [sse_pkg::DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [sse_pkg::DIV_NUM_W-1:0] quot_r, quot_nxt;
  logic [sse_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          done_r, done_nxt;
  logic [sse_pkg::DIV_DEN_W:0]   trial;
  logic [sse_pkg::DIV_DEN_W:0]   diff;

  assign trial = {rem_r, quot_r[sse_pkg::DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den};

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quot_nxt = num;
      cnt_nxt  = sse_pkg::DIV_CNT_W'(sse_pkg::DIV_NUM_W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt  = diff[sse_pkg::DIV_DEN_W-1:0];
        quot_nxt = {quot_r[sse_pkg::DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[sse_pkg::DIV_DEN_W-1:0];
        quot_nxt = {quot_r[sse_pkg::DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == sse_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### sv/sse_ctrl.sv
// ----------------------------------------------------------------------------
// sse_ctrl
// Sequencer: clear sweep, load, histogram scan, divides, result handoff.
// ----------------------------------------------------------------------------
module sse_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  sse_pkg::sts_t   sts,
  output sse_pkg::cmd_t   cmd
);

  typedef enum logic [10:0] {
    ST_CLEAR     = 11'b000_0000_0001,
    ST_LOAD      = 11'b000_0000_0010,
    ST_DRAIN     = 11'b000_0000_0100,
    ST_SCAN      = 11'b000_0000_1000,
    ST_TAIL      = 11'b000_0001_0000,
    ST_MULT      = 11'b000_0010_0000,
    ST_MEAN_GO   = 11'b000_0100_0000,
    ST_MEAN_WAIT = 11'b000_1000_0000,
    ST_VAR_GO    = 11'b001_0000_0000,
    ST_VAR_WAIT  = 11'b010_0000_0000,
    ST_RESULT    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.k_last) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // lets the final increment land before the scan reads
        cmd.scan_init = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.k_last) state_nxt = ST_TAIL;
      end
      ST_TAIL: state_nxt = ST_MULT;
      ST_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = ST_MEAN_GO;
      end
      ST_MEAN_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        cmd.mean_wait = 1'b1;
        if (sts.div_done) state_nxt = ST_VAR_GO;
      end
      ST_VAR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_var   = 1'b1;
        state_nxt     = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: begin
        cmd.div_var  = 1'b1;
        cmd.var_wait = 1'b1;
        if (sts.div_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/sse_datapath.sv
// ----------------------------------------------------------------------------
// sse_datapath
// Histogram and position memories, accumulators, scan, divides, output reg.
// ----------------------------------------------------------------------------
module sse_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  sse_pkg::cmd_t   cmd,
  output sse_pkg::sts_t   sts,
  input  sse_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sse_pkg::out_t   out_data
);

  localparam int unsigned VW = sse_pkg::VAL_W;
  localparam int unsigned CW = sse_pkg::CNT_W;

  logic [CW-1:0]             hist_mem [0:sse_pkg::VALUE_BINS-1];
  logic [sse_pkg::POS_W-1:0] lp_mem   [0:sse_pkg::VALUE_BINS-1];

  logic [VW-1:0]             s_sat;
  logic                      counted;
  logic [VW-1:0]             k_r;
  logic [CW-1:0]             hist_rd_r;
  logic [sse_pkg::POS_W-1:0] lp_rd_r;
  logic [VW-1:0]             hist_raddr;
  logic                      hist_we;
  logic [VW-1:0]             hist_waddr;
  logic [CW-1:0]             hist_wdata;

  // increment pipeline
  logic                      p_v_r;
  logic [VW-1:0]             p_addr_r;
  logic                      lw_v_r;
  logic [VW-1:0]             lw_addr_r;
  logic [CW-1:0]             lw_val_r;
  logic [CW-1:0]             inc_val;

  // accumulators
  logic [sse_pkg::SUM_W-1:0] sum_r;
  logic [sse_pkg::SQ_W-1:0]  sq_r;
  logic [CW-1:0]             count_r;
  logic [VW-1:0]             max_r, min_r;
  logic                      dropped_r;

  // scan
  logic                      s_v_r;
  logic [VW-1:0]             s_idx_r;
  logic [CW-1:0]             cum_r, cum_nxt;
  logic [CW-1:0]             best_r;
  logic [sse_pkg::POS_W-1:0] bestpos_r;
  logic [VW-1:0]             mode_r;
  logic                      lo_found_r, hi_found_r;
  logic [VW-1:0]             lo_r, hi_r;
  logic [CW-1:0]             rank_lo, rank_hi;

  // arithmetic
  logic [sse_pkg::PROD_W-1:0] nsq_r, ss_r, d_r;
  logic [sse_pkg::N2_W-1:0]   n2_r;
  logic [sse_pkg::DIV_NUM_W-1:0] div_num, div_quot;
  logic [sse_pkg::DIV_DEN_W-1:0] div_den;
  logic                          div_done;
  logic [14:0]                   mean_r;
  logic [19:0]                   var_r;

  sse_pkg::out_t out_r;
  logic          out_valid_r;

  assign s_sat   = (in_data.sample > sse_pkg::BIN_LAST) ? sse_pkg::BIN_LAST : in_data.sample;
  assign counted = cmd.load && (count_r != sse_pkg::CNT_MAX);

  // ---- memories ----
  assign hist_raddr = cmd.load ? s_sat : k_r;

  // read issued with a write to the same bin on the same edge sees stale data
  assign inc_val = ((lw_v_r && lw_addr_r == p_addr_r) ? lw_val_r : hist_rd_r) + 1'b1;

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = k_r;
    hist_wdata = '0;
    priority if (cmd.clear_wr) begin
      hist_we = 1'b1;
    end else if (p_v_r) begin
      hist_we    = 1'b1;
      hist_waddr = p_addr_r;
      hist_wdata = inc_val;
    end else if (s_v_r) begin
      hist_we    = 1'b1;       // clear on scan read
      hist_waddr = s_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rd_r <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (counted) lp_mem[s_sat] <= count_r[sse_pkg::POS_W-1:0];
    lp_rd_r <= lp_mem[k_r];
  end

  // ---- bin counter, increment pipeline ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      p_v_r  <= 1'b0;
      lw_v_r <= 1'b0;
      s_v_r  <= 1'b0;
    end else begin
      if (cmd.clear_wr || cmd.scan_issue) begin
        k_r <= (k_r == sse_pkg::BIN_LAST) ? '0 : k_r + 1'b1;
      end
      p_v_r  <= counted;
      lw_v_r <= p_v_r;
      s_v_r  <= cmd.scan_issue;
    end
    p_addr_r  <= s_sat;
    lw_addr_r <= p_addr_r;
    lw_val_r  <= inc_val;
    s_idx_r   <= k_r;
  end

  // ---- accumulators ----
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      sum_r     <= '0;
      sq_r      <= '0;
      count_r   <= '0;
      max_r     <= '0;
      min_r     <= sse_pkg::BIN_LAST;
      dropped_r <= 1'b0;
    end else if (cmd.load) begin
      if (counted) begin
        sum_r   <= sum_r + sse_pkg::SUM_W'(s_sat);
        sq_r    <= sq_r + sse_pkg::SQ_W'(s_sat * s_sat);
        count_r <= count_r + 1'b1;
        if (s_sat > max_r) max_r <= s_sat;
        if (s_sat < min_r) min_r <= s_sat;
      end else begin
        dropped_r <= 1'b1;
      end
    end
  end

  // ---- histogram scan: mode and the two median ranks in one pass ----
  assign rank_lo = (count_r - 1'b1) >> 1;
  assign rank_hi = count_r >> 1;
  assign cum_nxt = cum_r + hist_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cum_r      <= '0;
      best_r     <= '0;
      bestpos_r  <= '0;
      mode_r     <= '0;
      lo_found_r <= 1'b0;
      hi_found_r <= 1'b0;
      lo_r       <= sse_pkg::BIN_LAST;
      hi_r       <= sse_pkg::BIN_LAST;
    end else if (s_v_r) begin
      cum_r <= cum_nxt;
      if (hist_rd_r != '0 &&
          (hist_rd_r > best_r || (hist_rd_r == best_r && lp_rd_r > bestpos_r))) begin
        best_r    <= hist_rd_r;
        bestpos_r <= lp_rd_r;
        mode_r    <= s_idx_r;
      end
      if (!lo_found_r && cum_nxt > rank_lo) begin
        lo_found_r <= 1'b1;
        lo_r       <= s_idx_r;
      end
      if (!hi_found_r && cum_nxt > rank_hi) begin
        hi_found_r <= 1'b1;
        hi_r       <= s_idx_r;
      end
    end
  end

  // ---- products and divides ----
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      nsq_r <= sse_pkg::PROD_W'(count_r * sq_r);
      ss_r  <= sse_pkg::PROD_W'(sum_r * sum_r);
      n2_r  <= sse_pkg::N2_W'(count_r * count_r);
    end
    if (cmd.div_start && !cmd.div_var) d_r <= nsq_r - ss_r;
    if (cmd.mean_wait && div_done) mean_r <= div_quot[14:0];
    if (cmd.var_wait && div_done) var_r <= div_quot[19:0];
  end

  assign div_num = cmd.div_var ? {d_r, 8'h00}
                               : sse_pkg::DIV_NUM_W'({sum_r, 8'h00});
  assign div_den = cmd.div_var ? n2_r : sse_pkg::DIV_DEN_W'(count_r);

  sse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_r.mean_q8     <= mean_r;
      out_r.variance_q8 <= var_r;
      out_r.largest     <= max_r;
      out_r.smallest    <= min_r;
      out_r.mode_value  <= mode_r;
      out_r.median_x2   <= 8'(lo_r) + 8'(hi_r);
      out_r.set_size    <= count_r;
      out_r.overflow    <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.k_last   = (k_r == sse_pkg::BIN_LAST);
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

### sv/sample_statistics_engine.sv
// Samples load at one per cycle while in_ready is high; each sample updates the
// histogram through a read-increment-write on a one-read one-write memory with
// forwarding. After the final sample's transfer in_ready stays low through drain,
// scan of every bin, tail, multiply, two divides (start, steps, done) and handoff,
// which waits for out_busy to clear; the result then sits in an output register
// while the next set loads. After reset a sweep zeroes the histogram, in_ready low.
// ----------------------------------------------------------------------------
// sample_statistics_engine
// Mean, variance, min, max, mode and median of a streamed sample set.
// ----------------------------------------------------------------------------
module sample_statistics_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sse_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sse_pkg::out_t  out_data
);

  sse_pkg::cmd_t cmd;
  sse_pkg::sts_t sts;

  sse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sse_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sample sets into sample_statistics_engine and checks each set's stats
// against a built-in predictor or typed-in values, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  sse_pkg::in_t   in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  sse_pkg::out_t  out_data;

  sample_statistics_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // predictor state
  int unsigned bin_count [sse_pkg::VALUE_BINS];
  int unsigned bin_pos   [sse_pkg::VALUE_BINS];
  longint unsigned acc_sum, acc_sq, acc_n;
  int unsigned acc_max, acc_min;
  bit acc_drop;

  sse_pkg::out_t stats_queue [$];
  int   error_count = 0;
  int   hold_off = 0;

  typedef struct {
    logic [6:0]    sample;
    logic          last;
    bit            has_exp;
    sse_pkg::out_t expd;
  } row_t;

  function automatic void clear_stats();
    foreach (bin_count[i]) begin
      bin_count[i] = 0;
      bin_pos[i] = 0;
    end
    acc_sum = 0;
    acc_sq = 0;
    acc_n = 0;
    acc_max = 0;
    acc_min = sse_pkg::VALUE_BINS - 1;
    acc_drop = 1'b0;
  endfunction

  function automatic int unsigned rank_value(longint unsigned rank);
    longint unsigned cum = 0;
    for (int v = 0; v < sse_pkg::VALUE_BINS; v++) begin
      cum += bin_count[v];
      if (cum > rank) return v;
    end
    return sse_pkg::VALUE_BINS - 1;
  endfunction

  // returns 1 and fills res when the sample closes a set
  function automatic bit predict_stats(logic [6:0] smp, logic lst,
                                       output sse_pkg::out_t res);
    int unsigned s;
    longint unsigned n, n2, d, best, bestpos;
    int unsigned mode;
    s = (smp > sse_pkg::VALUE_BINS - 1) ? sse_pkg::VALUE_BINS - 1 : smp;
    res = '0;
    if (acc_n < sse_pkg::MAX_SAMPLES) begin
      bin_count[s]++;
      bin_pos[s] = acc_n[9:0];
      acc_sum += s;
      acc_sq += s * s;
      acc_n++;
      if (s > acc_max) acc_max = s;
      if (s < acc_min) acc_min = s;
    end else begin
      acc_drop = 1'b1;
    end
    if (!lst) return 1'b0;
    n = acc_n;
    if (n != 0) begin
      n2 = n * n;
      d = n * acc_sq - acc_sum * acc_sum;
      res.mean_q8 = 15'((acc_sum * 256) / n);
      res.variance_q8 = 20'((d / n2) * 256 + ((d % n2) * 256) / n2);
      best = 0;
      bestpos = 0;
      mode = 0;
      for (int v = 0; v < sse_pkg::VALUE_BINS; v++) begin
        if (bin_count[v] == 0) continue;
        if (bin_count[v] > best || (bin_count[v] == best && bin_pos[v] > bestpos)) begin
          best = bin_count[v];
          bestpos = bin_pos[v];
          mode = v;
        end
      end
      res.largest = 7'(acc_max);
      res.smallest = 7'(acc_min);
      res.mode_value = 7'(mode);
      res.median_x2 = 8'(rank_value((n - 1) / 2) + rank_value(n / 2));
      res.set_size = 11'(n);
      res.overflow = acc_drop;
    end
    clear_stats();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // send one sample; the typed-in expectation, if any, replaces the prediction.
  // Returns right after the transfer edge; valid drops only when a gap follows.
  task automatic send_sample(logic [6:0] smp, logic lst, bit has_exp,
                             sse_pkg::out_t expd);
    sse_pkg::out_t res;
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= '{sample: smp, last: lst};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (predict_stats(smp, lst, res)) stats_queue.push_back(has_exp ? expd : res);
  endtask

  task automatic send_set(int len, int lo, int hi);
    for (int i = 0; i < len; i++)
      send_sample(7'($urandom_range(lo, hi)), i == len - 1, 1'b0, '0);
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    sse_pkg::out_t want;
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (stats_queue.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = stats_queue.pop_front();
        if (out_data.mean_q8 !== want.mean_q8)
          report_mismatch("mean_q8", out_data.mean_q8, want.mean_q8);
        if (out_data.variance_q8 !== want.variance_q8)
          report_mismatch("variance_q8", out_data.variance_q8, want.variance_q8);
        if (out_data.largest !== want.largest)
          report_mismatch("largest", out_data.largest, want.largest);
        if (out_data.smallest !== want.smallest)
          report_mismatch("smallest", out_data.smallest, want.smallest);
        if (out_data.mode_value !== want.mode_value)
          report_mismatch("mode_value", out_data.mode_value, want.mode_value);
        if (out_data.median_x2 !== want.median_x2)
          report_mismatch("median_x2", out_data.median_x2, want.median_x2);
        if (out_data.set_size !== want.set_size)
          report_mismatch("set_size", out_data.set_size, want.set_size);
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", out_data.overflow, want.overflow);
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  initial begin
    int idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    row_t rows [$];
    sse_pkg::out_t e;
    int sent;
    int len;
    clear_stats();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single sample of zero, then single sample at top
    e = '0; e.set_size = 11'd1; e.mode_value = 7'd0;
    rows.push_back('{7'd0, 1'b1, 1'b1, e});
    e = '0; e.mean_q8 = 15'd25600; e.largest = 7'd100; e.smallest = 7'd100;
    e.mode_value = 7'd100; e.median_x2 = 8'd200; e.set_size = 11'd1;
    rows.push_back('{7'd100, 1'b1, 1'b1, e});
    // out of range saturates to top bin
    rows.push_back('{7'd127, 1'b1, 1'b1, e});
    // {0,100}: mean 50, var 2500, tie goes to latest arrival
    e = '0; e.mean_q8 = 15'd12800; e.variance_q8 = 20'd640000; e.largest = 7'd100;
    e.smallest = 7'd0; e.mode_value = 7'd100; e.median_x2 = 8'd100; e.set_size = 11'd2;
    rows.push_back('{7'd0, 1'b0, 1'b0, '0});
    rows.push_back('{7'd100, 1'b1, 1'b1, e});
    // odd set, median from histogram not from arrival order
    rows.push_back('{7'd90, 1'b0, 1'b0, '0});
    rows.push_back('{7'd5, 1'b0, 1'b0, '0});
    rows.push_back('{7'd42, 1'b0, 1'b0, '0});
    rows.push_back('{7'd5, 1'b0, 1'b0, '0});
    rows.push_back('{7'd101, 1'b1, 1'b0, '0});
    // mode tie decided by latest occurrence
    rows.push_back('{7'd7, 1'b0, 1'b0, '0});
    rows.push_back('{7'd9, 1'b0, 1'b0, '0});
    rows.push_back('{7'd9, 1'b0, 1'b0, '0});
    rows.push_back('{7'd7, 1'b1, 1'b0, '0});
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].last, rows[i].has_exp, rows[i].expd);
    sent = rows.size();

    // receiver holds off while several short sets back up the input
    hold_off = 1000;
    for (int k = 0; k < 6; k++) send_set(3, 0, 100);
    sent += 18;

    while (sent < 550) begin
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(1, 40);
          send_set(len, 0, 127);
        end
        1: begin
          len = $urandom_range(2, 20);
          send_set(len, 50, 52);
        end
        2: begin
          len = 1;
          send_set(len, 0, 127);
        end
        default: begin
          len = $urandom_range(2, 12);
          send_set(len, 0, 100);
        end
      endcase
      sent += len;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (stats_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
